FILE: rtl/two_level_pap_branch_predictor_unit_assert.svh
// Assertion macros for the two-level PAp branch predictor.
// Included by the top-level module, which carries the concurrent checks; no other dependencies.
`ifndef TWO_LEVEL_PAP_BRANCH_PREDICTOR_UNIT_ASSERT_SVH
`define TWO_LEVEL_PAP_BRANCH_PREDICTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLPAP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLPAP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tlpap_pkg.sv
// Shared types and constants for the two-level PAp branch predictor.
// No dependencies.
`default_nettype none

package tlpap_pkg;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    localparam logic [1:0] CTR_MIN   = 2'd0;
    localparam logic [1:0] CTR_TAKEN = 2'd2;
    localparam logic [1:0] CTR_MAX   = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [31:0] branch_addr;
        logic        outcome;
    } in_t;

    typedef struct packed {
        logic predict_taken;
        logic mispredicted;
    } out_t;

    // One pattern table entry: saturating counter and latched prediction
    typedef struct packed {
        logic [1:0] ctr;
        logic       lat;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/two_level_pap_branch_predictor_unit.sv
// Two-level PAp branch predictor, top level. Depends on tlpap_pkg and both stages.
// Path: history read at the accepting edge, pattern read, then the result register;
// throughput one transaction per cycle while m_ready is not held low, set by the
// memories with one-deep write bypass. After reset a clearing pass over all
// HIST_ENTRIES*HIST_ENTRIES entries (1024 at default) zeroes both memories, s_ready low.
`default_nettype none
`include "two_level_pap_branch_predictor_unit_assert.svh"

module two_level_pap_branch_predictor_unit
    import tlpap_pkg::*;
#(
    parameter int HIST_ENTRIES = 32
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int ROW_W = $clog2(HIST_ENTRIES);
    localparam int IDX_W = 2 * ROW_W;

    logic             clearing_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic             m_valid_reg;
    out_t             m_result_reg;

    logic             clr_hist;
    logic             hist_in_ready;
    logic             hist_valid;
    logic             pat_in_ready;
    in_t              hist_item;
    logic [IDX_W-1:0] hist_idx;
    logic             pat_valid;
    out_t             pat_result;
    logic             out_free;

    // history rows occupy the low end of the sweep
    assign clr_hist = clearing_reg && (clr_cnt_reg[IDX_W-1:ROW_W] == '0);
    assign s_ready  = !clearing_reg && hist_in_ready;
    assign out_free = !m_valid_reg || m_ready;

    tlpap_hist_stage #(
        .HIST_ENTRIES (HIST_ENTRIES)
    ) u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr_en    (clr_hist),
        .clr_row   (clr_cnt_reg[ROW_W-1:0]),
        .in_valid  (s_valid && !clearing_reg),
        .in_ready  (hist_in_ready),
        .in_item   (s_data),
        .out_valid (hist_valid),
        .out_ready (pat_in_ready),
        .out_item  (hist_item),
        .out_idx   (hist_idx)
    );

    tlpap_pat_stage #(
        .HIST_ENTRIES (HIST_ENTRIES)
    ) u_pat (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clr_en     (clearing_reg),
        .clr_idx    (clr_cnt_reg),
        .in_valid   (hist_valid),
        .in_ready   (pat_in_ready),
        .in_item    (hist_item),
        .in_idx     (hist_idx),
        .out_valid  (pat_valid),
        .out_ready  (out_free),
        .out_result (pat_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (out_free) begin
                m_valid_reg <= pat_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && pat_valid) begin
            m_result_reg <= pat_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_result_reg;

    `TLPAP_ASSERT_IMP(a_no_accept_clearing, aclk, aresetn, clearing_reg, !s_ready, "transaction accepted during clearing pass")
    `TLPAP_ASSERT_IMP(a_no_flight_clearing, aclk, aresetn, clearing_reg, !hist_valid && !pat_valid && !m_valid_reg, "transaction in flight during clearing pass")
    `TLPAP_ASSERT_NXT(a_clear_ends, aclk, aresetn, clearing_reg && (clr_cnt_reg == '1), !clearing_reg, "clearing pass did not end after last entry")
    `TLPAP_ASSERT_NXT(a_result_loaded, aclk, aresetn, pat_valid && out_free, m_valid_reg, "finished transaction not moved to result register")

endmodule

`default_nettype wire

FILE: rtl/tlpap_hist_stage.sv
// First stage: per-row history memory, history update and column calculation.
// Depends on tlpap_pkg.
`default_nettype none

module tlpap_hist_stage
    import tlpap_pkg::*;
#(
    parameter int HIST_ENTRIES = 32,
    localparam int ROW_W = $clog2(HIST_ENTRIES),
    localparam int IDX_W = 2 * ROW_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             clr_en,
    input  wire logic [ROW_W-1:0] clr_row,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_t              in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output in_t                   out_item,
    output logic [IDX_W-1:0]      out_idx
);

    logic [ROW_W-1:0] hist_mem [HIST_ENTRIES];

    logic             valid_reg;
    in_t              item_reg;
    logic [ROW_W-1:0] rd_reg;
    logic             byp_valid_reg;
    logic [ROW_W-1:0] byp_data_reg;

    logic             load;
    logic             move;
    logic             hist_we;
    logic [ROW_W-1:0] row_in;
    logic [ROW_W-1:0] row_cur;
    logic [ROW_W-1:0] hist_cur;
    logic [ROW_W-1:0] hist_new;
    logic [ROW_W-1:0] col;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign move     = valid_reg && out_ready;

    assign row_in  = in_item.branch_addr[ROW_W-1:0];
    assign row_cur = item_reg.branch_addr[ROW_W-1:0];

    // the read taken at accept misses a history write made on that same edge
    assign hist_cur = byp_valid_reg ? byp_data_reg : rd_reg;
    assign col      = hist_cur ^ row_cur;
    assign hist_new = ROW_W'({hist_cur, item_reg.outcome});
    assign hist_we  = move && (item_reg.cmd == CMD_UPDATE);

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_idx   = {row_cur, col};

    always_ff @(posedge aclk) begin
        if (clr_en) begin
            hist_mem[clr_row] <= '0;
        end else if (hist_we) begin
            hist_mem[row_cur] <= hist_new;
        end
        if (load) begin
            rd_reg       <= hist_mem[row_in];
            item_reg     <= in_item;
            byp_data_reg <= hist_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load) begin
                byp_valid_reg <= hist_we && (row_cur == row_in);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tlpap_pat_stage.sv
// Second stage: pattern table memory, counter and latched-bit update, result.
// Depends on tlpap_pkg.
`default_nettype none

module tlpap_pat_stage
    import tlpap_pkg::*;
#(
    parameter int HIST_ENTRIES = 32,
    localparam int ROW_W = $clog2(HIST_ENTRIES),
    localparam int IDX_W = 2 * ROW_W,
    localparam int DEPTH = HIST_ENTRIES * HIST_ENTRIES
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             clr_en,
    input  wire logic [IDX_W-1:0] clr_idx,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_t              in_item,
    input  wire logic [IDX_W-1:0] in_idx,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_t                  out_result
);

    entry_t pat_mem [DEPTH];

    logic             valid_reg;
    in_t              item_reg;
    logic [IDX_W-1:0] idx_reg;
    entry_t           rd_reg;
    logic             byp_valid_reg;
    entry_t           byp_data_reg;

    logic   load;
    logic   move;
    entry_t cur;
    entry_t nxt;
    logic   miss;
    out_t   res;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign move     = valid_reg && out_ready;

    assign cur  = byp_valid_reg ? byp_data_reg : rd_reg;
    assign miss = item_reg.outcome != cur.lat;

    always_comb begin
        nxt = cur;
        res = '0;
        if (item_reg.cmd == CMD_PREDICT) begin
            nxt.lat           = cur.ctr >= CTR_TAKEN;
            res.predict_taken = cur.ctr >= CTR_TAKEN;
        end else begin
            res.mispredicted = miss;
            if (item_reg.outcome) begin
                if (cur.ctr != CTR_MAX) begin
                    nxt.ctr = cur.ctr + 2'd1;
                    if (miss && nxt.ctr >= CTR_TAKEN) begin
                        nxt.lat = 1'b1;
                    end
                end
            end else begin
                if (cur.ctr != CTR_MIN) begin
                    nxt.ctr = cur.ctr - 2'd1;
                    if (miss && nxt.ctr < CTR_TAKEN) begin
                        nxt.lat = 1'b0;
                    end
                end
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = res;

    // entry is written back whenever the transaction leaves, predict or update
    always_ff @(posedge aclk) begin
        if (clr_en) begin
            pat_mem[clr_idx] <= '0;
        end else if (move) begin
            pat_mem[idx_reg] <= nxt;
        end
        if (load) begin
            rd_reg       <= pat_mem[in_idx];
            item_reg     <= in_item;
            idx_reg      <= in_idx;
            byp_data_reg <= nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load) begin
                byp_valid_reg <= move && (idx_reg == in_idx);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for two_level_pap_branch_predictor_unit.
// Uses tlpap_pkg for the transaction types; keeps its own copy of the history
// and pattern tables to work out each expected verdict.
module testbench
    import tlpap_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES      = 32;
    localparam int ROW_W        = $clog2(ENTRIES);
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 78;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Shadow of the predictor state
    logic [ROW_W-1:0]   hist_tab [ENTRIES];
    logic [1:0]         ctr_tab  [ENTRIES*ENTRIES];
    logic               lat_tab  [ENTRIES*ENTRIES];

    in_t  branch_q[$];        // items waiting to be offered
    out_t verdict_q[$];       // verdicts owed by the block, oldest first

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    // A few hot rows trained with short periodic outcome patterns
    logic [ROW_W-1:0] hot_row  [4];
    logic [7:0]       hot_pat  [4];
    int               hot_len  [4];
    int               hot_step [4];

    two_level_pap_branch_predictor_unit #(
        .HIST_ENTRIES(ENTRIES)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_t predict_branch(in_t it);
        logic [ROW_W-1:0]   row;
        logic [2*ROW_W-1:0] idx;
        logic [1:0]         c;
        logic               miss;
        out_t               r;
        row = it.branch_addr[ROW_W-1:0];
        idx = {row, hist_tab[row] ^ it.branch_addr[ROW_W-1:0]};
        c   = ctr_tab[idx];
        r   = '0;
        if (it.cmd == CMD_PREDICT) begin
            r.predict_taken = (c >= CTR_TAKEN);
            lat_tab[idx]    = r.predict_taken;
        end else begin
            miss           = (it.outcome != lat_tab[idx]);
            r.mispredicted = miss;
            if (it.outcome) begin
                if (c != CTR_MAX) begin
                    c = c + 2'd1;
                    if (miss && c >= CTR_TAKEN) lat_tab[idx] = 1'b1;
                end
            end else if (c != CTR_MIN) begin
                c = c - 2'd1;
                if (miss && c < CTR_TAKEN) lat_tab[idx] = 1'b0;
            end
            ctr_tab[idx]  = c;
            hist_tab[row] = {hist_tab[row][ROW_W-2:0], it.outcome};
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // Driver: offers queued items, records the verdict of each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready)
                verdict_q.push_back(predict_branch(s_data));
            if (!s_valid || s_ready) begin
                if (branch_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= branch_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, with an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = verdict_q.pop_front();
                if (m_data.predict_taken !== want.predict_taken)
                    report_mismatch($sformatf("predict_taken got %b want %b",
                                              m_data.predict_taken, want.predict_taken));
                if (m_data.mispredicted !== want.mispredicted)
                    report_mismatch($sformatf("mispredicted got %b want %b",
                                              m_data.mispredicted, want.mispredicted));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic push_item(logic cmd, logic [31:0] addr, logic taken);
        in_t it;
        it.cmd         = cmd;
        it.branch_addr = addr;
        it.outcome     = taken;
        branch_q.push_back(it);
    endtask

    task automatic queue_directed();
        @(negedge aclk);
        push_item(CMD_UPDATE, 32'h0000_0000, 1'b1);     // resolve with nothing latched
        push_item(CMD_PREDICT, 32'hFFFF_FFFF, 1'b1);
        push_item(CMD_UPDATE, 32'hFFFF_FFFF, 1'b0);
        // fill row 3 history with ones, then train one entry to saturation
        repeat (9) push_item(CMD_UPDATE, 32'hA5A5_A5A3, 1'b1);
        push_item(CMD_PREDICT, 32'h5A5A_5A43, 1'b0);
        push_item(CMD_UPDATE, 32'hA5A5_A5A3, 1'b0);     // mispredict, counter moves
        repeat (6) push_item(CMD_UPDATE, 32'h0000_0023, 1'b0);
        push_item(CMD_PREDICT, 32'h5A5A_5A5A, 1'b0);
        push_item(CMD_UPDATE, 32'h5A5A_5A5A, 1'b1);
    endtask

    task automatic queue_random(int n);
        int          k;
        int          s;
        logic [31:0] addr;
        logic        taken;
        @(negedge aclk);
        k = 0;
        while (k < n) begin
            if ($urandom_range(99) < 75) begin
                s    = $urandom_range(3);
                addr = $urandom();
                addr[ROW_W-1:0] = hot_row[s];
                taken = hot_pat[s][hot_step[s] % hot_len[s]];
                hot_step[s]++;
                if ($urandom_range(9) == 0) taken = !taken;
                push_item(CMD_PREDICT, addr, 1'($urandom_range(1)));
                push_item(CMD_UPDATE, addr, taken);
                k += 2;
            end else begin
                push_item(1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
                k++;
            end
        end
    endtask

    // Wait until every item is accepted and every verdict has come back
    task automatic settle();
        while (branch_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_rates(int send_pct, int recv_pct);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        foreach (hist_tab[i]) hist_tab[i] = '0;
        foreach (ctr_tab[i])  ctr_tab[i]  = CTR_MIN;
        foreach (lat_tab[i])  lat_tab[i]  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            hot_row[i]  = ROW_W'($urandom_range(ENTRIES - 1));
            hot_pat[i]  = 8'($urandom());
            hot_len[i]  = $urandom_range(1, 6);
            hot_step[i] = 0;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        set_rates(0, 0);
        queue_directed();
        settle();

        queue_random(RANDOM_ITEMS);
        settle();

        set_rates(61, 0);
        queue_random(RANDOM_ITEMS);
        settle();

        set_rates(0, 61);
        queue_random(RANDOM_ITEMS);
        settle();

        set_rates(23, 23);
        queue_random(RANDOM_ITEMS);
        settle();

        // long receiver hold-off while the sender keeps going
        set_rates(0, 0);
        hold_reqs = hold_reqs + 1;
        queue_random(40);
        settle();

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
